### design/tpm_pkg.sv
// tpm_pkg: shared types and constants for the period-to-rpm median block.
// No dependencies.
package tpm_pkg;

  localparam int unsigned RPM_BITS = 26;
  localparam logic [RPM_BITS-1:0] NUMERATOR_RESET = RPM_BITS'(18000000);

  typedef logic [RPM_BITS-1:0] rpm_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/tpm_if.sv
// Channel interfaces for the period-to-rpm median block.
// Depends on tpm_pkg.
interface tpm_period_if #(
  parameter int unsigned PERIOD_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [PERIOD_BITS-1:0] period_ticks;
  modport source (output valid, output period_ticks, input ready);
  modport sink   (input valid, input period_ticks, output ready);
endinterface

interface tpm_rpm_if;
  logic          valid;
  logic          ready;
  tpm_pkg::rpm_t median_rpm;
  modport source (output valid, output median_rpm, input ready);
  modport sink   (input valid, input median_rpm, output ready);
endinterface

interface tpm_cfg_if;
  logic          valid;
  logic          ready;
  tpm_pkg::rpm_t rpm_numerator;
  modport source (output valid, output rpm_numerator, input ready);
  modport sink   (input valid, input rpm_numerator, output ready);
endinterface

### design/tpm_div.sv
// tpm_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on tpm_pkg.
module tpm_div #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  tpm_pkg::rpm_t          numerator,
  input  logic [PERIOD_BITS-1:0] divisor,
  output tpm_pkg::rpm_t          quotient,
  output tpm_pkg::div_stat_t     stat
);

  localparam int unsigned CNT_W = $clog2(tpm_pkg::RPM_BITS);

  logic                   busy;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  tpm_pkg::rpm_t          num_sh;
  tpm_pkg::rpm_t          quo;
  logic [PERIOD_BITS-1:0] rem;
  logic [PERIOD_BITS-1:0] dvs;
  logic                   dvs_zero;
  logic [PERIOD_BITS:0]   trial;
  logic                   fits;

  assign trial = {rem, num_sh[tpm_pkg::RPM_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(tpm_pkg::RPM_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh   <= numerator;
      dvs      <= divisor;
      dvs_zero <= divisor == '0;
      rem      <= '0;
      quo      <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[tpm_pkg::RPM_BITS-2:0], 1'b0};
      quo    <= {quo[tpm_pkg::RPM_BITS-2:0], fits};
      if (fits) begin
        rem <= PERIOD_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[PERIOD_BITS-1:0];
      end
    end
  end

  assign quotient  = dvs_zero ? '0 : quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### design/tpm_median.sv
// tpm_median: rpm window shift line and rank scan, one candidate per cycle.
// Depends on tpm_pkg.
module tpm_median #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tpm_pkg::rpm_t rpm_value,
  output tpm_pkg::rpm_t median,
  output logic          done
);

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
  localparam int unsigned CW    = $clog2(WINDOW_LEN + 1);
  localparam logic [CW-1:0] MID = CW'(WINDOW_LEN / 2);

  tpm_pkg::rpm_t    win [WINDOW_LEN];
  logic             scanning;
  logic [IDX_W-1:0] idx;
  tpm_pkg::rpm_t    cand;
  logic [CW-1:0]    less_cnt;
  logic [CW-1:0]    leq_cnt;
  logic             hit;

  assign cand = win[idx];

  always_comb begin
    less_cnt = '0;
    leq_cnt  = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      less_cnt = less_cnt + CW'(win[j] < cand);
      leq_cnt  = leq_cnt + CW'(win[j] <= cand);
    end
  end

  assign hit = (less_cnt <= MID) && (leq_cnt > MID);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win[i] <= '0;
      end
      scanning <= 1'b0;
      done     <= 1'b0;
      idx      <= '0;
    end else begin
      done <= 1'b0;
      if (push) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[WINDOW_LEN-1] <= rpm_value;
        scanning <= 1'b1;
        idx      <= '0;
      end else if (scanning) begin
        if (hit || idx == IDX_W'(WINDOW_LEN - 1)) begin
          scanning <= 1'b0;
          done     <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scanning && hit) begin
      median <= cand;
    end
  end

endmodule

### design/tachometer_period_to_rpm_median.sv
// Top level: pulse period to rpm, then median of the last WINDOW_LEN values.
// Depends on tpm_pkg, tpm_if, tpm_div, tpm_median.
//
//  channel | dir | payload                  | request moves
//  period  | in  | period_ticks[PERIOD_BITS] | one measured period
//  rpm     | out | median_rpm[26]           | one median result
//  cfg     | in  | rpm_numerator[26]        | numerator register write
//
// A request passes through the divider, the rank scan and the output register
// in turn; at WINDOW_LEN = 5 the bit-serial divider is the slowest of these steps.
// rst is synchronous; it clears the window and loads numerator 18000000.
// A new request is taken while the previous result waits in the output
// register; the result stage holds until that register is free.
module tachometer_period_to_rpm_median #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  tpm_period_if.sink period,
  tpm_rpm_if.source  rpm,
  tpm_cfg_if.sink    cfg
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MED  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  tpm_pkg::rpm_t      numerator;
  tpm_pkg::rpm_t      quotient;
  tpm_pkg::rpm_t      median;
  tpm_pkg::div_stat_t div_stat;
  logic               med_done;
  logic               accept;
  logic               load_out;
  logic               out_valid;
  tpm_pkg::rpm_t      out_data;

  assign accept   = period.valid && period.ready;
  assign load_out = (state == S_OUT) && (!out_valid || rpm.ready);

  assign period.ready = state == S_IDLE;
  assign cfg.ready    = 1'b1;
  assign rpm.valid      = out_valid;
  assign rpm.median_rpm = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      numerator <= tpm_pkg::NUMERATOR_RESET;
    end else if (cfg.valid) begin
      numerator <= cfg.rpm_numerator;
    end
  end

  tpm_div #(.PERIOD_BITS(PERIOD_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .numerator(numerator),
    .divisor  (period.period_ticks),
    .quotient (quotient),
    .stat     (div_stat)
  );

  tpm_median #(.WINDOW_LEN(WINDOW_LEN)) u_med (
    .clk      (clk),
    .rst      (rst),
    .push     (div_stat.done),
    .rpm_value(quotient),
    .median   (median),
    .done     (med_done)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_DIV;
      S_DIV:  if (div_stat.done) state_next = S_MED;
      S_MED:  if (med_done) state_next = S_OUT;
      S_OUT:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rpm.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= median;
    end
  end

endmodule

### design/tpm_checker.sv
// tpm_checker: port-level checks for the period-to-rpm median block.
// Depends on tpm_pkg; bound to tachometer_period_to_rpm_median.
module tpm_checker (
  input logic          clk,
  input logic          rst,
  input logic          period_valid,
  input logic          period_ready,
  input logic          rpm_valid,
  input logic          rpm_ready,
  input tpm_pkg::rpm_t median_rpm,
  input logic          cfg_ready
);

  a_reset_out: assert property (@(posedge clk) rst |=> !rpm_valid)
    else $error("result valid after reset");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    period_valid && period_ready |=> !period_ready)
    else $error("new request taken while divide in flight");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(rpm_valid) |-> period_ready)
    else $error("result shown while input still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rpm_valid && !rpm_ready |=> rpm_valid && $stable(median_rpm))
    else $error("stalled result dropped or changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

endmodule

bind tachometer_period_to_rpm_median tpm_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .period_valid(period.valid),
  .period_ready(period.ready),
  .rpm_valid   (rpm.valid),
  .rpm_ready   (rpm.ready),
  .median_rpm  (rpm.median_rpm),
  .cfg_ready   (cfg.ready)
);

### test/tachometer_period_to_rpm_median_tb.sv
// Testbench for tachometer_period_to_rpm_median: random and directed periods, numerator writes,
// and an in-order check of every median_rpm against a local window-median predictor.
// Depends on tpm_pkg, tpm_if and the design top level.
`timescale 1ns / 100ps

module tachometer_period_to_rpm_median_tb;

  typedef tpm_pkg::rpm_t rpm_t;

  localparam int unsigned WINDOW_LEN       = 5;
  localparam int unsigned PERIOD_BITS      = 16;
  localparam int          PHASES           = 8;
  localparam int          ITEMS_PER_PHASE  = 210;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          PRINT_CAP        = 40;
  localparam rpm_t        NUMERATOR_MAX    = 26'h3FF_FFFF;

  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef enum int {MATCH, MISMATCH, UNEXPECTED} check_e;

  class rpm_median_scoreboard;
    rpm_t numerator;
    rpm_t window[WINDOW_LEN];
    rpm_t pending[$];

    function new();
      numerator = tpm_pkg::NUMERATOR_RESET;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void note_period(period_t p);
      rpm_t rpm;
      rpm_t sorted[WINDOW_LEN];
      rpm_t key;
      int   j;
      if (p == '0) rpm = '0;
      else rpm = rpm_t'(numerator / p);
      for (int i = 0; i + 1 < WINDOW_LEN; i++) window[i] = window[i+1];
      window[WINDOW_LEN-1] = rpm;
      sorted = window;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        key = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > key) begin
          sorted[j+1] = sorted[j];
          j--;
        end
        sorted[j+1] = key;
      end
      pending.push_back(sorted[WINDOW_LEN/2]);
    endfunction

    function check_e check_result(input rpm_t got, output rpm_t want);
      want = '0;
      if (pending.size() == 0) return UNEXPECTED;
      want = pending.pop_front();
      return (got === want) ? MATCH : MISMATCH;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tpm_period_if #(.PERIOD_BITS(PERIOD_BITS)) period_ch();
  tpm_rpm_if rpm_ch();
  tpm_cfg_if cfg_ch();

  tachometer_period_to_rpm_median #(
    .WINDOW_LEN (WINDOW_LEN),
    .PERIOD_BITS(PERIOD_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .period(period_ch),
    .rpm   (rpm_ch),
    .cfg   (cfg_ch)
  );

  always #5 clk = ~clk;

  rpm_median_scoreboard rpm_model;
  int     mismatches      = 0;
  int     periods_sent    = 0;
  int     zero_periods    = 0;
  int     medians_checked = 0;
  int     numerator_sets  = 0;
  int     long_holds_asked = 0;
  bit     no_gaps         = 1'b0;
  period_t last_period    = '0;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_rpm(rpm_t got);
    rpm_t   want;
    check_e verdict;
    verdict = rpm_model.check_result(got, want);
    medians_checked++;
    if (verdict == UNEXPECTED)
      report_mismatch($sformatf("median_rpm %0d with no request pending", got));
    else if (verdict == MISMATCH)
      report_mismatch($sformatf("median_rpm %0d, want %0d", got, want));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic period_t gen_period();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 15) return last_period;
    if (r < 45) return period_t'($urandom_range(255, 1));
    if (r < 55) return period_t'($urandom_range(65535, 65000));
    return period_t'($urandom());
  endfunction

  task automatic send_period(period_t p, int gap);
    period_ch.valid        <= 1'b1;
    period_ch.period_ticks <= p;
    @(posedge clk);
    while (!period_ch.ready) @(posedge clk);
    rpm_model.note_period(p);
    periods_sent++;
    if (p == '0) zero_periods++;
    last_period = p;
    if (gap > 0) begin
      period_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    period_ch.valid <= 1'b0;
    @(posedge clk);
    while (rpm_model.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_numerator(rpm_t value);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.rpm_numerator <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    rpm_model.numerator = value;
    numerator_sets++;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic rpm_t phase_numerator(int phase);
    case (phase)
      0: return 26'd1;
      1: return NUMERATOR_MAX;
      2: return 26'd0;
      3: return 26'd4096;
      4: return tpm_pkg::NUMERATOR_RESET;
      5: return rpm_t'($urandom_range(262140, 1));
      default: return rpm_t'($urandom());
    endcase
  endfunction

  // Result side: random stalls, plus long holds requested by the stimulus.
  initial begin : rpm_sink
    int stall_left;
    int holds_taken;
    stall_left  = 0;
    holds_taken = 0;
    rpm_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rpm_ch.valid && rpm_ch.ready) check_rpm(rpm_ch.median_rpm);
      if (holds_taken < long_holds_asked) begin
        holds_taken++;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rpm_ch.ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(99) < 30) begin
        stall_left = pick_gap();
        rpm_ch.ready <= 1'b0;
      end else begin
        rpm_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    period_t default_periods[14];
    period_t max_periods[5];
    rpm_model = new();
    default_periods = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA,
                        16'd255, 16'd256, 16'd1000, 16'd0, 16'd0, 16'd7};
    max_periods = '{16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd1};
    rst                    <= 1'b1;
    period_ch.valid        <= 1'b0;
    period_ch.period_ticks <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.rpm_numerator   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset numerator, edge periods
    foreach (default_periods[i]) send_period(default_periods[i], pick_gap());
    wait_for_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      write_numerator(phase_numerator(phase));
      no_gaps = (phase == 4);
      if (phase == 1) begin
        foreach (max_periods[i]) send_period(max_periods[i], pick_gap());
        long_holds_asked++;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) wait_for_results();
        send_period(gen_period(), pick_gap());
      end
      wait_for_results();
    end
    no_gaps = 1'b0;

    repeat (60) @(posedge clk);
    if (rpm_model.pending.size() != 0)
      report_mismatch($sformatf("%0d medians never arrived", rpm_model.pending.size()));
    $display("Sent %0d periods (%0d zero) over %0d numerator settings; %0d medians checked.",
             periods_sent, zero_periods, numerator_sets, medians_checked);
    $display("Included min, max and zero numerators, a long result hold and a drained pause.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout at %0t with %0d medians pending", $time, rpm_model.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
